>>> hw/rtl/mvhd_pkg.sv
// ----------------------------------------------------------------------------
// mvhd_pkg: shared types and constants
// Parse states, result status codes, controller/datapath command and status
// groups, and the field sizes of the movie header.
// ----------------------------------------------------------------------------
package mvhd_pkg;

  localparam logic [31:0] TAG_MVHD = 32'h6D76_6864;

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] SKIP_SHORT  = CNT_W'(11);
  localparam logic [CNT_W-1:0] SKIP_LONG   = CNT_W'(19);
  localparam logic [CNT_W-1:0] SCALE_BYTES = CNT_W'(4);
  localparam logic [CNT_W-1:0] UNITS_SHORT = CNT_W'(4);
  localparam logic [CNT_W-1:0] UNITS_LONG  = CNT_W'(8);

  localparam logic [7:0] VERSION_LONG = 8'd1;

  localparam int UNITS_W   = 64;
  localparam int SCALE_W   = 32;
  localparam int DIV_CNT_W = $clog2(UNITS_W);

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_SEARCH,
    ST_VERSION,
    ST_SKIP,
    ST_SCALE,
    ST_UNITS,
    ST_DONE,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    logic shift_tag;
    logic load_version;
    logic dec_count;
    logic load_scale_count;
    logic load_units_count;
    logic shift_scale;
    logic shift_units;
    logic clear;
    logic div_start;
    logic out_load_zero;
    logic out_load_miss;
    logic out_load_div;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tag_hit;
    logic count_one;
    logic fields_nonzero;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hw/rtl/mvhd_ifs.sv
// ----------------------------------------------------------------------------
// mvhd stream interfaces
// Valid/ready channels for the file bytes and for the header results.
// ----------------------------------------------------------------------------
interface mvhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface mvhd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] duration_seconds;
  logic [31:0] time_scale;
  logic [63:0] time_units;
  logic [1:0]  status;

  modport source (output valid, output duration_seconds, output time_scale,
                  output time_units, output status, input ready);
  modport sink   (input valid, input duration_seconds, input time_scale,
                  input time_units, input status, output ready);
endinterface

>>> hw/rtl/mvhd_div.sv
// ----------------------------------------------------------------------------
// mvhd_div: iterative unsigned divider
// Restoring division of the duration by the timescale, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module mvhd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mvhd_pkg::UNITS_W-1:0] dividend,
  input  logic [mvhd_pkg::SCALE_W-1:0] divisor,
  output logic                         busy,
  output logic [mvhd_pkg::UNITS_W-1:0] quotient
);

  logic                           busy_r, busy_nxt;
  logic [mvhd_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [mvhd_pkg::UNITS_W-1:0]   quo_r, quo_nxt;
  logic [mvhd_pkg::SCALE_W-1:0]   rem_r, rem_nxt;
  logic [mvhd_pkg::SCALE_W-1:0]   dsr_r, dsr_nxt;
  logic [mvhd_pkg::SCALE_W:0]     rem_sh;
  logic                           ge;

  assign rem_sh = {rem_r, quo_r[mvhd_pkg::UNITS_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[mvhd_pkg::UNITS_W-2:0], ge};
      rem_nxt = ge ? mvhd_pkg::SCALE_W'(rem_sh - {1'b0, dsr_r})
                   : mvhd_pkg::SCALE_W'(rem_sh);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/mvhd_dp.sv
// ----------------------------------------------------------------------------
// mvhd_dp: header datapath
// Tag window, byte counter, field accumulators, divider and result register.
// ----------------------------------------------------------------------------
module mvhd_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mvhd_pkg::ctrl_cmd_t          cmd,
  input  logic [7:0]                   byte_value,
  input  logic                         out_ready,
  output mvhd_pkg::dp_stat_t           stat,
  output logic                         out_valid,
  output logic [mvhd_pkg::UNITS_W-1:0] out_secs,
  output logic [mvhd_pkg::SCALE_W-1:0] out_scale,
  output logic [mvhd_pkg::UNITS_W-1:0] out_units,
  output logic [1:0]                   out_status
);

  logic [31:0]                  tag_r, tag_nxt, tag_shift;
  logic [mvhd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         long_r, long_nxt;
  logic [mvhd_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic [mvhd_pkg::UNITS_W-1:0] units_r, units_nxt, units_shift;
  logic [mvhd_pkg::SCALE_W-1:0] res_scale_r;
  logic [mvhd_pkg::UNITS_W-1:0] res_units_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [mvhd_pkg::UNITS_W-1:0] out_secs_r;
  logic [mvhd_pkg::SCALE_W-1:0] out_scale_r;
  logic [mvhd_pkg::UNITS_W-1:0] out_units_r;
  mvhd_pkg::status_t            out_status_r;
  logic                         div_busy;
  logic [mvhd_pkg::UNITS_W-1:0] quotient;
  logic                         is_long;

  assign tag_shift   = {tag_r[23:0], byte_value};
  assign units_shift = {units_r[mvhd_pkg::UNITS_W-9:0], byte_value};
  assign is_long     = byte_value == mvhd_pkg::VERSION_LONG;

  mvhd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (units_shift),
    .divisor  (scale_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    tag_nxt   = tag_r;
    cnt_nxt   = cnt_r;
    long_nxt  = long_r;
    scale_nxt = scale_r;
    units_nxt = units_r;
    if (cmd.clear) begin
      tag_nxt   = '0;
      cnt_nxt   = '0;
      long_nxt  = 1'b0;
      scale_nxt = '0;
      units_nxt = '0;
    end else begin
      if (cmd.shift_tag) begin
        tag_nxt = tag_shift;
      end
      if (cmd.shift_scale) begin
        scale_nxt = {scale_r[mvhd_pkg::SCALE_W-9:0], byte_value};
      end
      if (cmd.shift_units) begin
        units_nxt = units_shift;
      end
      if (cmd.load_version) begin
        long_nxt = is_long;
        cnt_nxt  = is_long ? mvhd_pkg::SKIP_LONG : mvhd_pkg::SKIP_SHORT;
      end else if (cmd.load_scale_count) begin
        cnt_nxt = mvhd_pkg::SCALE_BYTES;
      end else if (cmd.load_units_count) begin
        cnt_nxt = long_r ? mvhd_pkg::UNITS_LONG : mvhd_pkg::UNITS_SHORT;
      end else if (cmd.dec_count) begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load_zero || cmd.out_load_miss || cmd.out_load_div) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r       <= '0;
      cnt_r       <= '0;
      long_r      <= 1'b0;
      scale_r     <= '0;
      units_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tag_r       <= tag_nxt;
      cnt_r       <= cnt_nxt;
      long_r      <= long_nxt;
      scale_r     <= scale_nxt;
      units_r     <= units_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      res_scale_r <= scale_r;
      res_units_r <= units_shift;
    end
    if (cmd.out_load_zero) begin
      out_secs_r   <= '0;
      out_scale_r  <= scale_r;
      out_units_r  <= units_shift;
      out_status_r <= mvhd_pkg::STAT_ZERO;
    end else if (cmd.out_load_miss) begin
      out_secs_r   <= '0;
      out_scale_r  <= '0;
      out_units_r  <= '0;
      out_status_r <= mvhd_pkg::STAT_MISS;
    end else if (cmd.out_load_div) begin
      out_secs_r   <= quotient;
      out_scale_r  <= res_scale_r;
      out_units_r  <= res_units_r;
      out_status_r <= mvhd_pkg::STAT_OK;
    end
  end

  assign stat.tag_hit        = tag_shift == mvhd_pkg::TAG_MVHD;
  assign stat.count_one      = cnt_r == mvhd_pkg::CNT_W'(1);
  assign stat.fields_nonzero = (scale_r != '0) && (units_shift != '0);
  assign stat.div_busy       = div_busy;
  assign stat.out_free       = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_secs   = out_secs_r;
  assign out_scale  = out_scale_r;
  assign out_units  = out_units_r;
  assign out_status = out_status_r;

endmodule

>>> hw/rtl/mvhd_ctrl.sv
// ----------------------------------------------------------------------------
// mvhd_ctrl: parse controller
// Steps through tag search, version, skip, timescale and duration fields,
// then loads the result register, after the divider when both are nonzero.
// ----------------------------------------------------------------------------
module mvhd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  mvhd_pkg::dp_stat_t  stat,
  output mvhd_pkg::ctrl_cmd_t cmd
);

  mvhd_pkg::state_t state_r, state_nxt;
  logic             last_pend_r, last_pend_nxt;
  logic             accept;
  logic             units_done;

  assign in_ready   = (state_r != mvhd_pkg::ST_DIVIDE) && stat.out_free;
  assign accept     = in_valid && in_ready;
  assign units_done = accept && (state_r == mvhd_pkg::ST_UNITS) && stat.count_one;

  always_comb begin
    state_nxt     = state_r;
    last_pend_nxt = last_pend_r;
    unique case (state_r)
      mvhd_pkg::ST_SEARCH: begin
        if (accept && stat.tag_hit) state_nxt = mvhd_pkg::ST_VERSION;
      end
      mvhd_pkg::ST_VERSION: begin
        if (accept) state_nxt = mvhd_pkg::ST_SKIP;
      end
      mvhd_pkg::ST_SKIP: begin
        if (accept && stat.count_one) state_nxt = mvhd_pkg::ST_SCALE;
      end
      mvhd_pkg::ST_SCALE: begin
        if (accept && stat.count_one) state_nxt = mvhd_pkg::ST_UNITS;
      end
      mvhd_pkg::ST_UNITS: begin
        if (units_done) begin
          if (stat.fields_nonzero) begin
            state_nxt     = mvhd_pkg::ST_DIVIDE;
            last_pend_nxt = in_last;
          end else begin
            state_nxt = mvhd_pkg::ST_DONE;
          end
        end
      end
      mvhd_pkg::ST_DONE: begin
        state_nxt = mvhd_pkg::ST_DONE;
      end
      mvhd_pkg::ST_DIVIDE: begin
        if (!stat.div_busy && stat.out_free) begin
          state_nxt     = last_pend_r ? mvhd_pkg::ST_SEARCH : mvhd_pkg::ST_DONE;
          last_pend_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = mvhd_pkg::ST_SEARCH;
      end
    endcase
    if (accept && in_last && state_nxt != mvhd_pkg::ST_DIVIDE) begin
      state_nxt = mvhd_pkg::ST_SEARCH;
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      mvhd_pkg::ST_SEARCH: begin
        cmd.shift_tag = accept;
      end
      mvhd_pkg::ST_VERSION: begin
        cmd.load_version = accept;
      end
      mvhd_pkg::ST_SKIP: begin
        cmd.dec_count        = accept;
        cmd.load_scale_count = accept && stat.count_one;
      end
      mvhd_pkg::ST_SCALE: begin
        cmd.shift_scale      = accept;
        cmd.dec_count        = accept;
        cmd.load_units_count = accept && stat.count_one;
      end
      mvhd_pkg::ST_UNITS: begin
        cmd.shift_units   = accept;
        cmd.dec_count     = accept;
        cmd.div_start     = units_done && stat.fields_nonzero;
        cmd.out_load_zero = units_done && !stat.fields_nonzero;
      end
      mvhd_pkg::ST_DONE: begin
        cmd.dec_count = 1'b0;
      end
      mvhd_pkg::ST_DIVIDE: begin
        cmd.out_load_div = !stat.div_busy && stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
    if (accept && in_last) begin
      cmd.clear = 1'b1;
      if (!units_done && state_r != mvhd_pkg::ST_DONE) begin
        cmd.out_load_miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvhd_pkg::ST_SEARCH;
      last_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

endmodule

>>> hw/rtl/mp4_movie_header_duration.sv
// Takes one file byte per cycle while the header is searched and read and the result register is free.
// A zero-field or missing/truncated result is registered in the cycle after its byte.
// A header with nonzero fields holds input while the divider retires its 64
// quotient bits, one per cycle, and until the result register is free and loads.
// Reset is synchronous, active low, and returns the parser to tag search.
// ----------------------------------------------------------------------------
// mp4_movie_header_duration: MP4 movie header duration parser
// Finds the first mvhd tag per file, gathers timescale and duration, and
// returns whole seconds with the raw fields and a status code.
// ----------------------------------------------------------------------------
module mp4_movie_header_duration (
  input  logic              clk,
  input  logic              rst_n,
  mvhd_in_if.sink           in_ch,
  mvhd_out_if.source        out_ch
);

  mvhd_pkg::ctrl_cmd_t cmd;
  mvhd_pkg::dp_stat_t  stat;
  logic                in_ready;

  mvhd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_byte),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mvhd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .byte_value (in_ch.byte_value),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .out_valid  (out_ch.valid),
    .out_secs   (out_ch.duration_seconds),
    .out_scale  (out_ch.time_scale),
    .out_units  (out_ch.time_units),
    .out_status (out_ch.status)
  );

  assign in_ch.ready = in_ready;

`ifndef NO_ASSERTIONS
  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> stat.div_busy)
    else $error("divider did not start");

  a_hold_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_busy |-> !in_ready)
    else $error("request accepted during division");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.out_load_zero, cmd.out_load_miss, cmd.out_load_div}))
    else $error("conflicting result loads");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load_zero || cmd.out_load_miss || cmd.out_load_div) |-> stat.out_free)
    else $error("result register overwritten");
`endif

endmodule

>>> tb/mp4_movie_header_duration_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp4_movie_header_duration_tb: self-checking bench for the mvhd duration parser
// Streams byte files through the input channel: well-formed headers of both
// versions, truncated and tagless files. Every accepted byte runs through a
// local parser model, and each result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module mp4_movie_header_duration_tb;

  localparam int     ITEM_TARGET  = 1300;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     DRAIN_CYCLES = 100;
  localparam longint LIMIT_NS     = 3_000_000;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } file_byte_t;

  typedef struct {
    logic [63:0]        seconds;
    logic [31:0]        scale;
    logic [63:0]        units;
    mvhd_pkg::status_t  status;
  } header_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mvhd_in_if  in_ch ();
  mvhd_out_if out_ch ();

  mp4_movie_header_duration u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  file_byte_t     request_q[$];
  header_result_t expected_q[$];
  int             total_requests = 0;
  int             sent_requests  = 0;
  int             mismatches     = 0;
  int             hold_left      = 0;
  logic           hold_done      = 1'b0;
  logic           queue_filled   = 1'b0;

  logic [31:0]       tag_window;
  mvhd_pkg::state_t  parse_state;
  logic [4:0]        bytes_left;
  logic              long_fields;
  logic              result_given;
  logic [31:0]       scale_acc;
  logic [63:0]       units_acc;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_parser();
    tag_window   = '0;
    parse_state  = mvhd_pkg::ST_SEARCH;
    bytes_left   = '0;
    long_fields  = 1'b0;
    result_given = 1'b0;
    scale_acc    = '0;
    units_acc    = '0;
  endfunction

  function automatic void parse_mvhd_byte(input logic [7:0] b, input logic last);
    header_result_t r;
    logic           got;
    got = 1'b0;
    case (parse_state)
      mvhd_pkg::ST_SEARCH: begin
        tag_window = {tag_window[23:0], b};
        if (tag_window == mvhd_pkg::TAG_MVHD) parse_state = mvhd_pkg::ST_VERSION;
      end
      mvhd_pkg::ST_VERSION: begin
        long_fields = (b == mvhd_pkg::VERSION_LONG);
        bytes_left  = long_fields ? mvhd_pkg::SKIP_LONG : mvhd_pkg::SKIP_SHORT;
        parse_state = mvhd_pkg::ST_SKIP;
      end
      mvhd_pkg::ST_SKIP: begin
        bytes_left = bytes_left - 5'd1;
        if (bytes_left == 5'd0) begin
          bytes_left  = mvhd_pkg::SCALE_BYTES;
          parse_state = mvhd_pkg::ST_SCALE;
        end
      end
      mvhd_pkg::ST_SCALE: begin
        scale_acc  = {scale_acc[23:0], b};
        bytes_left = bytes_left - 5'd1;
        if (bytes_left == 5'd0) begin
          bytes_left  = long_fields ? mvhd_pkg::UNITS_LONG : mvhd_pkg::UNITS_SHORT;
          parse_state = mvhd_pkg::ST_UNITS;
        end
      end
      mvhd_pkg::ST_UNITS: begin
        units_acc  = {units_acc[55:0], b};
        bytes_left = bytes_left - 5'd1;
        if (bytes_left == 5'd0) begin
          if (scale_acc != '0 && units_acc != '0)
            r = '{units_acc / {32'd0, scale_acc}, scale_acc, units_acc,
                  mvhd_pkg::STAT_OK};
          else
            r = '{64'd0, scale_acc, units_acc, mvhd_pkg::STAT_ZERO};
          got          = 1'b1;
          result_given = 1'b1;
          parse_state  = mvhd_pkg::ST_DONE;
        end
      end
      default: ;
    endcase
    if (last) begin
      if (!result_given && !got) begin
        r   = '{64'd0, 32'd0, 64'd0, mvhd_pkg::STAT_MISS};
        got = 1'b1;
      end
      clear_parser();
    end
    if (got) expected_q.push_back(r);
  endfunction

  function automatic int load_phase();
    if (sent_requests < total_requests / 3) return 0;
    if (sent_requests < 2 * total_requests / 3) return 1;
    return 2;
  endfunction

  task automatic push_file(input logic [7:0] bytes[$], input int keep);
    for (int i = 0; i < keep; i++) request_q.push_back('{bytes[i], i == keep - 1});
  endtask

  task automatic append_header(ref logic [7:0] bytes[$]);
    logic [7:0]  version;
    logic [31:0] scale;
    logic [63:0] units;
    int          pick;
    int          units_bytes;
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 1)) bytes.push_back(8'($urandom_range(0, 255)));
      else bytes.push_back(mvhd_pkg::TAG_MVHD[8 * $urandom_range(0, 3) +: 8]);
    end
    for (int i = 3; i >= 0; i--) bytes.push_back(mvhd_pkg::TAG_MVHD[8 * i +: 8]);
    pick = $urandom_range(0, 9);
    if (pick <= 3) version = 8'd0;
    else if (pick <= 7) version = mvhd_pkg::VERSION_LONG;
    else version = 8'($urandom_range(2, 255));
    bytes.push_back(version);
    repeat ((version == mvhd_pkg::VERSION_LONG) ? mvhd_pkg::SKIP_LONG : mvhd_pkg::SKIP_SHORT)
      bytes.push_back(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 9))
      0:       scale = '0;
      1:       scale = '1;
      2, 3:    scale = 32'($urandom_range(1, 1000));
      default: scale = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       units = '0;
      1:       units = '1;
      2, 3:    units = {32'd0, scale} * 64'($urandom_range(1, 5000));
      default: units = {$urandom, $urandom};
    endcase
    for (int i = 3; i >= 0; i--) bytes.push_back(scale[8 * i +: 8]);
    units_bytes = (version == mvhd_pkg::VERSION_LONG) ? 8 : 4;
    for (int i = units_bytes - 1; i >= 0; i--) bytes.push_back(units[8 * i +: 8]);
  endtask

  task automatic add_random_file();
    logic [7:0] bytes[$];
    int         kind;
    kind = $urandom_range(0, 99);
    if (kind < 85) append_header(bytes);
    if (kind >= 95) append_header(bytes);
    if (kind >= 70 && kind < 85) begin
      push_file(bytes, $urandom_range(1, bytes.size() - 1));
    end else begin
      repeat ((kind >= 85 && kind < 95) ? $urandom_range(1, 20) : $urandom_range(0, 5))
        bytes.push_back(8'($urandom_range(0, 255)));
      push_file(bytes, bytes.size());
    end
  endtask

  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (queue_filled) begin
      if (in_ch.valid && in_ch.ready) begin
        parse_mvhd_byte(in_ch.byte_value, in_ch.last_byte);
        void'(request_q.pop_front());
        sent_requests <= sent_requests + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        offer = request_q.size() != 0 &&
                $urandom_range(0, 99) >= (load_phase() == 0 ? 35 :
                                          load_phase() == 1 ? 61 : 0);
        in_ch.valid <= offer;
        if (offer) begin
          in_ch.byte_value <= request_q[0].value;
          in_ch.last_byte  <= request_q[0].last;
        end
      end
    end
  end

  always @(posedge clk) begin
    header_result_t seen;
    header_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.duration_seconds, out_ch.time_scale, out_ch.time_units,
                 mvhd_pkg::status_t'(out_ch.status)};
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result secs=%0d scale=%0d units=%0d status=%0d",
                   $time, seen.seconds, seen.scale, seen.units, seen.status);
        end else begin
          want = expected_q.pop_front();
          if (seen.seconds !== want.seconds || seen.scale !== want.scale ||
              seen.units !== want.units || seen.status !== want.status) begin
            mismatches++;
            $display("%0t: expected secs=%0d scale=%0d units=%0d status=%0d", $time,
                     want.seconds, want.scale, want.units, want.status);
            $display("%0t: actual   secs=%0d scale=%0d units=%0d status=%0d", $time,
                     seen.seconds, seen.scale, seen.units, seen.status);
          end
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (!hold_done && load_phase() == 2) begin
        // hold off results so the parser backs up into its input
        out_ch.ready <= 1'b0;
        hold_left    <= HOLD_CYCLES;
        hold_done    <= 1'b1;
      end else begin
        out_ch.ready <= $urandom_range(0, 99) >= (load_phase() == 0 ? 61 :
                                                  load_phase() == 1 ? 35 : 0);
      end
    end
  end

  initial begin
    logic [7:0] bytes[$];
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.byte_value = 8'h00;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    clear_parser();

    bytes = '{8'hFF};
    push_file(bytes, 1);

    bytes.delete();
    for (int i = 3; i >= 0; i--) bytes.push_back(mvhd_pkg::TAG_MVHD[8 * i +: 8]);
    bytes.push_back(8'h00);
    repeat (mvhd_pkg::SKIP_SHORT) bytes.push_back(8'h00);
    for (int i = 0; i < 3; i++) bytes.push_back(8'h00);
    bytes.push_back(8'h01);
    repeat (4) bytes.push_back(8'hFF);
    push_file(bytes, bytes.size());

    while (request_q.size() < ITEM_TARGET) add_random_file();
    total_requests = request_q.size();
    queue_filled   = 1'b1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mvhd_pkg.sv
hw/rtl/mvhd_ifs.sv
hw/rtl/mvhd_div.sv
hw/rtl/mvhd_dp.sv
hw/rtl/mvhd_ctrl.sv
hw/rtl/mp4_movie_header_duration.sv
tb/mp4_movie_header_duration_tb.sv
